/* src/html_entity_scanner_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef HTML_ENTITY_SCANNER_CORE_DEFINES_SVH
`define HTML_ENTITY_SCANNER_CORE_DEFINES_SVH

// Check a property on every clock edge, including edges inside reset.
`define HES_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property outside reset only.
`define HES_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* src/hes_pkg.sv */
`default_nettype none

package hes_pkg;

   localparam int NAME_MAX_LEN   = 32;
   localparam int NUM_MAX_DIGITS = 8;
   localparam int POS_W          = 6;

   localparam logic [POS_W-1:0] LIMIT_NAME = POS_W'(1 + NAME_MAX_LEN);
   localparam logic [POS_W-1:0] LIMIT_DEC  = POS_W'(2 + NUM_MAX_DIGITS);
   localparam logic [POS_W-1:0] LIMIT_HEX  = POS_W'(3 + NUM_MAX_DIGITS);

   localparam logic [7:0] CHAR_AMP   = 8'h26;  // &
   localparam logic [7:0] CHAR_HASH  = 8'h23;  // #
   localparam logic [7:0] CHAR_X_UP  = 8'h58;  // X
   localparam logic [7:0] CHAR_X_LOW = 8'h78;  // x
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_AMP,
      PH_HASH,
      PH_BODY
   } phase_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

   function automatic logic is_hex(input logic [7:0] b);
      return is_digit(b) || ((b >= 8'h41) && (b <= 8'h46)) ||
             ((b >= 8'h61) && (b <= 8'h66));
   endfunction

endpackage

`default_nettype wire

/* src/html_entity_scanner_core.sv */
// HTML character reference recognizer.
// Input channel (req_*): one text byte per word, with a scan start flag that
// marks the '&' opening a reference and a text end flag on the last byte.
// Result channel (rsp_*): one word per finished scan, giving a found flag and
// the length from '&' to ';' inclusive (0 when not found). Recognized forms
// are &name;, &#digits; and &#x / &#X followed by hex digits.
// Result timing: the result of the byte that decides a scan is registered and
// appears on rsp_* in the cycle after that byte is accepted. Bytes that
// leave the scan undecided, and bytes outside a scan, give no result word.
// Throughput: one byte per cycle while req_ready is high; the single state
// update per byte is the only loop, closed through the scan state registers.
// Stall: the result sits in one output register. While it is waiting, a new
// byte is accepted only in the cycle the receiver takes the held word, so
// req_ready follows rsp_ready whenever a result is pending.
// Reset: synchronous, active high; returns the scanner to idle and empties
// the output register. Bytes arriving while idle are dropped.
`default_nettype none

module html_entity_scanner_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_in_byte,
   input  wire logic                        req_scan_start,
   input  wire logic                        req_text_end,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_entity_found,
   output logic [hes_pkg::POS_W-1:0]        rsp_entity_length
);

   // scan state
   hes_pkg::phase_type            phase_ff, phase_in;
   logic                          numeric_ff, numeric_in;
   logic                          hex_ff, hex_in;
   logic                          nonempty_ff, nonempty_in;
   logic [hes_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [hes_pkg::POS_W-1:0]     limit_ff, limit_in;

   // output register
   logic                          valid_ff, valid_in;
   logic                          found_ff, found_in;
   logic [hes_pkg::POS_W-1:0]     length_ff, length_in;

   logic                          accept;
   logic                          emit;
   logic [hes_pkg::POS_W-1:0]     body_limit;
   logic                          body_char_ok;
   logic                          is_semi;

   // take a byte whenever the output register is free or being drained
   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // the first body byte after "&#" is checked against the decimal limit
   assign body_limit = (phase_ff == hes_pkg::PH_HASH) ? hes_pkg::LIMIT_DEC : limit_ff;
   assign is_semi    = (req_in_byte == hes_pkg::CHAR_SEMI);

   always_comb begin
      if (hex_ff) begin
         body_char_ok = hes_pkg::is_hex(req_in_byte);
      end else if (numeric_ff) begin
         body_char_ok = hes_pkg::is_digit(req_in_byte);
      end else begin
         body_char_ok = hes_pkg::is_alpha(req_in_byte) || hes_pkg::is_digit(req_in_byte);
      end
   end

   // next scan state and result for the byte on the input ports
   always_comb begin
      phase_in    = phase_ff;
      numeric_in  = numeric_ff;
      hex_in      = hex_ff;
      nonempty_in = nonempty_ff;
      pos_in      = pos_ff;
      limit_in    = limit_ff;
      emit        = 1'b0;
      found_in    = 1'b0;
      length_in   = '0;

      if (req_scan_start) begin
         // drop any scan in progress and restart
         phase_in    = hes_pkg::PH_IDLE;
         numeric_in  = 1'b0;
         hex_in      = 1'b0;
         nonempty_in = 1'b0;
         pos_in      = '0;
         limit_in    = '0;
         if (req_in_byte == hes_pkg::CHAR_AMP) begin
            phase_in = hes_pkg::PH_AMP;
            pos_in   = hes_pkg::POS_W'(1);
         end else begin
            emit = 1'b1;
         end
      end else begin
         case (phase_ff)
            hes_pkg::PH_AMP: begin
               if (req_in_byte == hes_pkg::CHAR_HASH) begin
                  numeric_in = 1'b1;
                  pos_in     = hes_pkg::POS_W'(2);
                  phase_in   = hes_pkg::PH_HASH;
               end else if (hes_pkg::is_alpha(req_in_byte)) begin
                  pos_in      = hes_pkg::POS_W'(2);
                  nonempty_in = 1'b1;
                  limit_in    = hes_pkg::LIMIT_NAME;
                  phase_in    = hes_pkg::PH_BODY;
               end else begin
                  emit     = 1'b1;
                  phase_in = hes_pkg::PH_IDLE;
               end
            end
            hes_pkg::PH_HASH, hes_pkg::PH_BODY: begin
               if ((phase_ff == hes_pkg::PH_HASH) &&
                   ((req_in_byte == hes_pkg::CHAR_X_LOW) ||
                    (req_in_byte == hes_pkg::CHAR_X_UP))) begin
                  hex_in   = 1'b1;
                  pos_in   = hes_pkg::POS_W'(3);
                  limit_in = hes_pkg::LIMIT_HEX;
                  phase_in = hes_pkg::PH_BODY;
               end else begin
                  limit_in = body_limit;
                  phase_in = hes_pkg::PH_BODY;
                  if (is_semi) begin
                     // close the reference; an empty body is a miss
                     emit      = 1'b1;
                     found_in  = nonempty_ff;
                     length_in = nonempty_ff ? (pos_ff + hes_pkg::POS_W'(1)) : '0;
                     phase_in  = hes_pkg::PH_IDLE;
                  end else if (body_char_ok && (pos_ff < body_limit)) begin
                     pos_in      = pos_ff + hes_pkg::POS_W'(1);
                     nonempty_in = 1'b1;
                  end else begin
                     emit     = 1'b1;
                     phase_in = hes_pkg::PH_IDLE;
                  end
               end
            end
            default: begin
               // idle: ignore the byte
            end
         endcase
      end

      // text ran out before a decision
      if (!emit && req_text_end && (phase_in != hes_pkg::PH_IDLE)) begin
         emit      = 1'b1;
         found_in  = 1'b0;
         length_in = '0;
         phase_in  = hes_pkg::PH_IDLE;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = emit;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= hes_pkg::PH_IDLE;
         numeric_ff  <= 1'b0;
         hex_ff      <= 1'b0;
         nonempty_ff <= 1'b0;
         pos_ff      <= '0;
         limit_ff    <= '0;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            phase_ff    <= phase_in;
            numeric_ff  <= numeric_in;
            hex_ff      <= hex_in;
            nonempty_ff <= nonempty_in;
            pos_ff      <= pos_in;
            limit_ff    <= limit_in;
         end
      end
   end

   // result payload: load only with a new word
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         found_ff  <= found_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_entity_found  = found_ff;
   assign rsp_entity_length = length_ff;

endmodule

`default_nettype wire

/* src/hes_checker.sv */
`default_nettype none
`include "html_entity_scanner_core_defines.svh"

module hes_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic                     rsp_entity_found,
   input wire logic [hes_pkg::POS_W-1:0] rsp_entity_length
);

   // result word shape and hold terms
   logic                       miss;
   logic                       hit;
   logic                       len_zero;
   logic                       len_legal;
   logic                       stall;
   logic [hes_pkg::POS_W+1:0]  rsp_word;

   assign miss      = rsp_valid && !rsp_entity_found;
   assign hit       = rsp_valid && rsp_entity_found;
   assign len_zero  = (rsp_entity_length == '0);
   assign len_legal = (rsp_entity_length >= hes_pkg::POS_W'(3)) &&
                      (rsp_entity_length <= hes_pkg::POS_W'(hes_pkg::NAME_MAX_LEN + 2));
   assign stall     = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_valid, rsp_entity_found, rsp_entity_length};

   `HES_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result word after reset")

   `HES_ASSERT_RUN(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "stall while empty")

   `HES_ASSERT_RUN(a_miss_zero_len, clock, reset, miss |-> len_zero, "miss with nonzero length")

   `HES_ASSERT_RUN(a_hit_len_range, clock, reset, hit |-> len_legal, "hit length out of range")

   `HES_ASSERT_RUN(a_rsp_hold, clock, reset, stall |=> $stable(rsp_word), "word changed in stall")

endmodule

bind html_entity_scanner_core hes_checker u_hes_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_entity_found  (rsp_entity_found),
   .rsp_entity_length (rsp_entity_length)
);

`default_nettype wire
